/* hdl/ipl_pkg.sv */
// Package for the indexed pointer list core.
// Holds the request/response payload types, controller command and status types.
// No dependencies.
package ipl_pkg;

	localparam int POS_W  = 9;
	localparam int WORD_W = 32;
	localparam int IDX_W  = 9;
	localparam int CNT_W  = 9;

	typedef enum logic [2:0] {
		OP_GET    = 3'd0,
		OP_SET    = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_FIND   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] word_in;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [WORD_W-1:0] word_out;
		logic [IDX_W-1:0]  index_out;
		logic [CNT_W-1:0]  entry_count;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_GET_RD,
		ST_GET_DATA,
		ST_SWEEP,
		ST_SET_WR,
		ST_MOVE,
		ST_DRAIN,
		ST_PUT,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_START,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_CLR,
		CNT_INC,
		CNT_DEC,
		CNT_SET
	} cnt_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_ZERO,
		WR_WORD
	} wr_sel_t;

	typedef enum logic [1:0] {
		IOUT_NONE,
		IOUT_AT,
		IOUT_RD
	} iout_sel_t;

	typedef struct packed {
		logic      latch;
		logic      res_clr;
		ptr_op_t   ptr_op;
		logic      rd_en;
		logic      arm;
		wr_sel_t   wr_sel;
		cnt_op_t   cnt_op;
		logic      set_ok;
		iout_sel_t iout_sel;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic pos_lt_cnt;
		logic pos_lt_depth;
		logic pos_gt_cnt;
		logic pos_ge_cnt;
		logic cnt_lt_depth;
		logic cnt_gt_at;
		logic cnt_zero;
		logic ptr_eq_at;
		logic ptr_eq_last;
		logic ptr_eq_pos;
		logic ptr_next_pos;
		logic match;
	} sts_t;

endpackage

/* hdl/ipl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/ipl_ctrl.sv */
// Controller state machine for the indexed pointer list core.
// Depends on ipl_pkg; drives commands into ipl_dpath.
module ipl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  ipl_pkg::sts_t sts,
	output ipl_pkg::cmd_t cmd
);

	ipl_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ipl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign req_ready = (state_q == ipl_pkg::ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.ptr_op   = ipl_pkg::PTR_HOLD;
		cmd.wr_sel   = ipl_pkg::WR_NONE;
		cmd.cnt_op   = ipl_pkg::CNT_HOLD;
		cmd.iout_sel = ipl_pkg::IOUT_NONE;
		unique case (state_q)
			ipl_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = ipl_pkg::ST_DECODE;
				end
			end
			ipl_pkg::ST_DECODE: begin
				cmd.res_clr = 1'b1;
				cmd.ptr_op  = ipl_pkg::PTR_START;
				state_d     = ipl_pkg::ST_RESP;
				case (sts.op)
					ipl_pkg::OP_GET: begin
						if (sts.pos_lt_cnt) state_d = ipl_pkg::ST_GET_RD;
					end
					ipl_pkg::OP_SET: begin
						if (sts.pos_lt_depth) begin
							state_d = sts.pos_gt_cnt ? ipl_pkg::ST_SWEEP : ipl_pkg::ST_SET_WR;
						end
					end
					ipl_pkg::OP_INSERT: begin
						if (sts.cnt_lt_depth) begin
							state_d = sts.cnt_gt_at ? ipl_pkg::ST_MOVE : ipl_pkg::ST_PUT;
						end
					end
					ipl_pkg::OP_DELETE: begin
						if (sts.pos_lt_cnt) state_d = ipl_pkg::ST_MOVE;
					end
					ipl_pkg::OP_FIND: begin
						if (!sts.cnt_zero) state_d = ipl_pkg::ST_MOVE;
					end
					ipl_pkg::OP_CLEAR: begin
						cmd.cnt_op = ipl_pkg::CNT_CLR;
						cmd.set_ok = 1'b1;
					end
					default: ;
				endcase
			end
			ipl_pkg::ST_GET_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ipl_pkg::ST_GET_DATA;
			end
			ipl_pkg::ST_GET_DATA: begin
				cmd.set_ok = 1'b1;
				state_d    = ipl_pkg::ST_RESP;
			end
			ipl_pkg::ST_SWEEP: begin
				cmd.wr_sel = ipl_pkg::WR_ZERO;
				if (sts.ptr_next_pos) begin
					state_d = ipl_pkg::ST_SET_WR;
				end else begin
					cmd.ptr_op = ipl_pkg::PTR_INC;
				end
			end
			ipl_pkg::ST_SET_WR: begin
				cmd.wr_sel = ipl_pkg::WR_WORD;
				cmd.cnt_op = sts.pos_ge_cnt ? ipl_pkg::CNT_SET : ipl_pkg::CNT_HOLD;
				cmd.set_ok = 1'b1;
				state_d    = ipl_pkg::ST_RESP;
			end
			ipl_pkg::ST_MOVE: begin
				cmd.rd_en = 1'b1;
				case (sts.op)
					ipl_pkg::OP_INSERT: begin
						cmd.arm = 1'b1;
						if (sts.ptr_eq_at) state_d = ipl_pkg::ST_DRAIN;
						else cmd.ptr_op = ipl_pkg::PTR_DEC;
					end
					ipl_pkg::OP_DELETE: begin
						cmd.arm = !sts.ptr_eq_pos;
						if (sts.ptr_eq_last) state_d = ipl_pkg::ST_DRAIN;
						else cmd.ptr_op = ipl_pkg::PTR_INC;
					end
					default: begin
						if (sts.match) begin
							cmd.set_ok   = 1'b1;
							cmd.iout_sel = ipl_pkg::IOUT_RD;
							state_d      = ipl_pkg::ST_RESP;
						end else if (sts.ptr_eq_last) begin
							state_d = ipl_pkg::ST_DRAIN;
						end else begin
							cmd.ptr_op = ipl_pkg::PTR_INC;
						end
					end
				endcase
			end
			ipl_pkg::ST_DRAIN: begin
				state_d = ipl_pkg::ST_RESP;
				case (sts.op)
					ipl_pkg::OP_INSERT: state_d = ipl_pkg::ST_PUT;
					ipl_pkg::OP_DELETE: begin
						cmd.cnt_op = ipl_pkg::CNT_DEC;
						cmd.set_ok = 1'b1;
					end
					default: begin
						if (sts.match) begin
							cmd.set_ok   = 1'b1;
							cmd.iout_sel = ipl_pkg::IOUT_RD;
						end
					end
				endcase
			end
			ipl_pkg::ST_PUT: begin
				cmd.wr_sel   = ipl_pkg::WR_WORD;
				cmd.cnt_op   = ipl_pkg::CNT_INC;
				cmd.set_ok   = 1'b1;
				cmd.iout_sel = ipl_pkg::IOUT_AT;
				state_d      = ipl_pkg::ST_RESP;
			end
			ipl_pkg::ST_RESP: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ipl_pkg::ST_IDLE;
				end
			end
			default: state_d = ipl_pkg::ST_IDLE;
		endcase
	end

endmodule

/* hdl/ipl_dpath.sv */
// Datapath for the indexed pointer list core: request latch, count, scan pointer,
// entry RAM, move write-back, result and response registers.
// Depends on ipl_pkg and ipl_ram.
module ipl_dpath #(
	parameter int DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ipl_pkg::req_t req,
	output ipl_pkg::rsp_t rsp,
	input  ipl_pkg::cmd_t cmd,
	output ipl_pkg::sts_t sts
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > ipl_pkg::POS_W) ? CW : ipl_pkg::POS_W;

	ipl_pkg::req_t               req_q;
	ipl_pkg::rsp_t               rsp_q;
	logic [CW-1:0]               cnt_q;
	logic [AW-1:0]               ptr_q;
	logic [AW-1:0]               wa_q;
	logic [AW-1:0]               rd_idx_q;
	logic                        rvalid_q;
	logic                        pend_q;
	logic                        cap_q;
	logic                        ok_q;
	logic [ipl_pkg::WORD_W-1:0]  wout_q;
	logic [ipl_pkg::IDX_W-1:0]   iout_q;

	ipl_pkg::op_t                op;
	logic [XW-1:0]               pos_x, cnt_x, ptr_x, at_x, start_x, set_x, rd_x;
	logic                        we;
	logic [AW-1:0]               waddr;
	logic [ipl_pkg::WORD_W-1:0]  wdata;
	logic [ipl_pkg::WORD_W-1:0]  rdata;

	assign op      = ipl_pkg::op_t'(req_q.req_type);
	assign pos_x   = XW'(req_q.position);
	assign cnt_x   = XW'(cnt_q);
	assign ptr_x   = XW'(ptr_q);
	assign rd_x    = XW'(rd_idx_q);
	assign at_x    = (pos_x > cnt_x) ? cnt_x : pos_x;
	assign set_x   = pos_x + XW'(1);

	always_comb begin
		case (op)
			ipl_pkg::OP_SET:    start_x = cnt_x;
			ipl_pkg::OP_INSERT: start_x = cnt_x - XW'(1);
			ipl_pkg::OP_FIND:   start_x = '0;
			default:            start_x = pos_x;
		endcase
	end

	always_comb begin
		sts              = '0;
		sts.op           = op;
		sts.pos_lt_cnt   = pos_x < cnt_x;
		sts.pos_lt_depth = pos_x < XW'(DEPTH);
		sts.pos_gt_cnt   = pos_x > cnt_x;
		sts.pos_ge_cnt   = pos_x >= cnt_x;
		sts.cnt_lt_depth = cnt_x < XW'(DEPTH);
		sts.cnt_gt_at    = cnt_x > at_x;
		sts.cnt_zero     = (cnt_q == '0);
		sts.ptr_eq_at    = ptr_x == at_x;
		sts.ptr_eq_last  = (ptr_x + XW'(1)) == cnt_x;
		sts.ptr_eq_pos   = ptr_x == pos_x;
		sts.ptr_next_pos = (ptr_x + XW'(1)) == pos_x;
		sts.match        = rvalid_q && (rdata == req_q.word_in);
	end

	// move write-back has the port whenever a shifted entry is in flight
	always_comb begin
		we    = 1'b0;
		waddr = wa_q;
		wdata = rdata;
		if (pend_q) begin
			we = 1'b1;
		end else begin
			case (cmd.wr_sel)
				ipl_pkg::WR_ZERO: begin
					we    = 1'b1;
					waddr = ptr_q;
					wdata = '0;
				end
				ipl_pkg::WR_WORD: begin
					we    = 1'b1;
					waddr = (op == ipl_pkg::OP_INSERT) ? at_x[AW-1:0] : pos_x[AW-1:0];
					wdata = req_q.word_in;
				end
				default: ;
			endcase
		end
	end

	ipl_ram #(
		.WIDTH(ipl_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
			pend_q   <= 1'b0;
			cap_q    <= 1'b0;
		end else begin
			rvalid_q <= cmd.rd_en;
			pend_q   <= cmd.rd_en && cmd.arm;
			cap_q    <= cmd.rd_en && sts.ptr_eq_pos
				&& (op == ipl_pkg::OP_GET || op == ipl_pkg::OP_DELETE);
			case (cmd.cnt_op)
				ipl_pkg::CNT_CLR: cnt_q <= '0;
				ipl_pkg::CNT_INC: cnt_q <= cnt_q + CW'(1);
				ipl_pkg::CNT_DEC: cnt_q <= cnt_q - CW'(1);
				ipl_pkg::CNT_SET: cnt_q <= set_x[CW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		case (cmd.ptr_op)
			ipl_pkg::PTR_START: ptr_q <= start_x[AW-1:0];
			ipl_pkg::PTR_INC:   ptr_q <= ptr_q + AW'(1);
			ipl_pkg::PTR_DEC:   ptr_q <= ptr_q - AW'(1);
			default: ;
		endcase
		if (cmd.rd_en) begin
			rd_idx_q <= ptr_q;
			wa_q     <= (op == ipl_pkg::OP_INSERT) ? ptr_q + AW'(1) : ptr_q - AW'(1);
		end
		if (cmd.res_clr) begin
			ok_q   <= cmd.set_ok;
			wout_q <= '0;
			iout_q <= '0;
		end else begin
			if (cmd.set_ok) ok_q <= 1'b1;
			if (cap_q) wout_q <= rdata;
			case (cmd.iout_sel)
				ipl_pkg::IOUT_AT: iout_q <= at_x[ipl_pkg::IDX_W-1:0];
				ipl_pkg::IOUT_RD: iout_q <= rd_x[ipl_pkg::IDX_W-1:0];
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			rsp_q.ok          <= ok_q;
			rsp_q.word_out    <= wout_q;
			rsp_q.index_out   <= iout_q;
			rsp_q.entry_count <= cnt_x[ipl_pkg::CNT_W-1:0];
		end
	end

	assign rsp = rsp_q;

endmodule

/* hdl/indexed_pointer_list_core.sv */
// Top level of the indexed pointer list core: ordered list of 32-bit words in a RAM.
// Depends on ipl_pkg, ipl_ctrl, ipl_dpath (which holds ipl_ram).
//
//   channel | signals                      | transaction
//   req     | req_valid, req_ready, req    | one request: type, position, word
//   rsp     | rsp_valid, rsp_ready, rsp    | one response per request
//
// One request at a time. Set past the end first zeroes the skipped slots, one per
// cycle. Insert, delete and find walk the RAM one entry per cycle through its single
// read port.
// Reset clears the count; RAM contents are not cleared.
// A response waiting on rsp_ready does not block the next request from being taken.
module indexed_pointer_list_core #(
	parameter int DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ipl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ipl_pkg::rsp_t rsp
);

	ipl_pkg::cmd_t cmd;
	ipl_pkg::sts_t sts;

	ipl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ipl_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cmd   (cmd),
		.sts   (sts)
	);

endmodule

/* hdl/ipl_checker.sv */
// Port-level checks for the indexed pointer list core, and their bind.
// Depends on ipl_pkg and indexed_pointer_list_core.
module ipl_checker #(
	parameter int DEPTH = 256
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input ipl_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ipl_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.word_out == '0 && rsp.index_out == '0)
		else $error("failed transaction carries nonzero word or index");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (DEPTH > 511) || (32'(rsp.entry_count) <= DEPTH))
		else $error("entry count beyond depth");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

endmodule

bind indexed_pointer_list_core ipl_checker #(.DEPTH(DEPTH)) u_ipl_checker (.*);

/* verif/tb_indexed_pointer_list_core.sv */
// Testbench for indexed_pointer_list_core: drives get/set/insert/delete/find/clear and
// reserved requests and checks each response against an in-bench model of the word list.
// Depends on ipl_pkg and the indexed_pointer_list_core RTL.
`timescale 1ns / 100ps

module tb_indexed_pointer_list_core;

	localparam int LIST_DEPTH   = 256;
	localparam int ITEMS_PHASE  = 550;
	localparam int STALL_LIMIT  = 5000;
	localparam int RSP_HOLD     = 400;
	localparam int TAIL_CYCLES  = 600;
	localparam logic [2:0] REQ_RSVD6 = 3'd6;
	localparam logic [2:0] REQ_RSVD7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	ipl_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	ipl_pkg::rsp_t rsp;

	// list model
	logic [ipl_pkg::WORD_W-1:0] list_mem [LIST_DEPTH];
	int list_len = 0;

	ipl_pkg::req_t pending_reqs[$];
	ipl_pkg::rsp_t expected_rsps[$];
	ipl_pkg::rsp_t expected_head;

	// stimulus shaping
	int gen_count = 0;
	logic [ipl_pkg::WORD_W-1:0] word_pool [8];

	int send_idle_pct = 13;
	int recv_idle_pct = 45;
	int rsp_hold_left = 0;
	int error_count = 0;
	int stall_cycles = 0;

	indexed_pointer_list_core #(
		.DEPTH(LIST_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic ipl_pkg::rsp_t apply_list_req(input ipl_pkg::req_t r);
		ipl_pkg::rsp_t res;
		int at;
		res = '0;
		case (r.req_type)
			ipl_pkg::OP_GET: begin
				if (r.position < list_len) begin
					res.ok = 1'b1;
					res.word_out = list_mem[r.position];
				end
			end
			ipl_pkg::OP_SET: begin
				if (r.position < LIST_DEPTH) begin
					if (r.position >= list_len) begin
						for (int i = list_len; i < int'(r.position); i++)
							list_mem[i] = '0;
						list_len = int'(r.position) + 1;
					end
					list_mem[r.position] = r.word_in;
					res.ok = 1'b1;
				end
			end
			ipl_pkg::OP_INSERT: begin
				if (list_len < LIST_DEPTH) begin
					at = (r.position > list_len) ? list_len : int'(r.position);
					for (int i = list_len; i > at; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[at] = r.word_in;
					list_len++;
					res.ok = 1'b1;
					res.index_out = ipl_pkg::IDX_W'(at);
				end
			end
			ipl_pkg::OP_DELETE: begin
				if (r.position < list_len) begin
					res.word_out = list_mem[r.position];
					for (int i = int'(r.position); i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
					res.ok = 1'b1;
				end
			end
			ipl_pkg::OP_FIND: begin
				// scan downward so the lowest match wins
				for (int i = list_len - 1; i >= 0; i--) begin
					if (list_mem[i] == r.word_in) begin
						res.ok = 1'b1;
						res.index_out = ipl_pkg::IDX_W'(i);
					end
				end
			end
			ipl_pkg::OP_CLEAR: begin
				list_len = 0;
				res.ok = 1'b1;
			end
			default: begin
			end
		endcase
		res.entry_count = ipl_pkg::CNT_W'(list_len);
		return res;
	endfunction

	task automatic push_req(input logic [2:0] kind, input int pos,
		input logic [ipl_pkg::WORD_W-1:0] word);
		ipl_pkg::req_t r;
		r.req_type = kind;
		r.position = ipl_pkg::POS_W'(pos);
		r.word_in = word;
		pending_reqs.push_back(r);
		case (kind)
			ipl_pkg::OP_SET: begin
				if (pos < LIST_DEPTH && pos >= gen_count)
					gen_count = pos + 1;
			end
			ipl_pkg::OP_INSERT: begin
				if (gen_count < LIST_DEPTH)
					gen_count++;
			end
			ipl_pkg::OP_DELETE: begin
				if (pos < gen_count)
					gen_count--;
			end
			ipl_pkg::OP_CLEAR: gen_count = 0;
			default: begin
			end
		endcase
		if (kind == ipl_pkg::OP_SET || kind == ipl_pkg::OP_INSERT)
			word_pool[$urandom_range(0, 7)] = word;
	endtask

	task automatic push_random_reqs(input int n);
		int roll;
		int pos;
		logic [2:0] kind;
		logic [ipl_pkg::WORD_W-1:0] word;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 18)
				kind = ipl_pkg::OP_GET;
			else if (roll < 34)
				kind = ipl_pkg::OP_SET;
			else if (roll < 56)
				kind = ipl_pkg::OP_INSERT;
			else if (roll < 78)
				kind = ipl_pkg::OP_DELETE;
			else if (roll < 93)
				kind = ipl_pkg::OP_FIND;
			else if (roll < 96)
				kind = ipl_pkg::OP_CLEAR;
			else
				kind = $urandom_range(0, 1) ? REQ_RSVD7 : REQ_RSVD6;
			if ($urandom_range(0, 9) == 0)
				pos = $urandom_range(0, 511);
			else
				pos = $urandom_range(0, gen_count + 1);
			if (kind == ipl_pkg::OP_SET && $urandom_range(0, 99) == 0)
				pos = LIST_DEPTH - 1;
			case ($urandom_range(0, 3))
				0, 1: word = word_pool[$urandom_range(0, 7)];
				2: word = $urandom;
				default: word = $urandom_range(0, 3);
			endcase
			push_req(kind, pos, word);
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready)
				expected_rsps.push_back(apply_list_req(req));
			if (!req_valid || req_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					error_count++;
					$error("unexpected response transaction: %h", rsp);
				end else begin
					expected_head = expected_rsps.pop_front();
					if (rsp.ok !== expected_head.ok) begin
						error_count++;
						$error("ok: expected %0d, got %0d", expected_head.ok, rsp.ok);
					end
					if (rsp.word_out !== expected_head.word_out) begin
						error_count++;
						$error("word_out: expected %h, got %h",
							expected_head.word_out, rsp.word_out);
					end
					if (rsp.index_out !== expected_head.index_out) begin
						error_count++;
						$error("index_out: expected %0d, got %0d",
							expected_head.index_out, rsp.index_out);
					end
					if (rsp.entry_count !== expected_head.entry_count) begin
						error_count++;
						$error("entry_count: expected %0d, got %0d",
							expected_head.entry_count, rsp.entry_count);
					end
				end
			end
			if (rsp_hold_left > 0) begin
				rsp_hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < 8; i++)
			word_pool[i] = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners
		push_req(ipl_pkg::OP_GET, 0, 32'h0000_0000);
		push_req(ipl_pkg::OP_DELETE, 0, 32'h0000_0000);
		push_req(ipl_pkg::OP_FIND, 0, 32'h0000_0000);
		push_req(ipl_pkg::OP_CLEAR, 0, 32'h0000_0000);
		push_req(ipl_pkg::OP_SET, 511, 32'hFFFF_FFFF);
		push_req(ipl_pkg::OP_SET, LIST_DEPTH, 32'h1111_1111);
		push_req(ipl_pkg::OP_SET, 3, 32'hA5A5_A5A5);
		push_req(ipl_pkg::OP_GET, 1, 32'h0000_0000);
		push_req(ipl_pkg::OP_FIND, 0, 32'h0000_0000);
		push_req(ipl_pkg::OP_INSERT, 511, 32'h0000_0000);
		push_req(ipl_pkg::OP_INSERT, 0, 32'hFFFF_FFFF);
		push_req(ipl_pkg::OP_FIND, 0, 32'hFFFF_FFFF);
		push_req(ipl_pkg::OP_DELETE, 0, 32'h0000_0000);
		push_req(ipl_pkg::OP_GET, 511, 32'h0000_0000);
		push_req(REQ_RSVD6, 0, 32'h0000_0000);
		push_req(REQ_RSVD7, 511, 32'hFFFF_FFFF);
		push_req(ipl_pkg::OP_SET, LIST_DEPTH - 1, 32'h1234_5678);
		push_req(ipl_pkg::OP_INSERT, 0, 32'h5A5A_5A5A);
		push_req(ipl_pkg::OP_GET, LIST_DEPTH - 1, 32'h0000_0000);
		push_req(ipl_pkg::OP_FIND, 0, 32'h1234_5678);
		push_req(ipl_pkg::OP_FIND, 0, 32'hDEAD_BEEF);
		push_req(ipl_pkg::OP_DELETE, LIST_DEPTH - 1, 32'h0000_0000);
		push_req(ipl_pkg::OP_DELETE, 511, 32'h0000_0000);
		push_req(ipl_pkg::OP_INSERT, LIST_DEPTH - 1, 32'h0000_0000);
		push_req(ipl_pkg::OP_CLEAR, 0, 32'h0000_0000);
		wait_drained();

		push_random_reqs(ITEMS_PHASE);
		wait_drained();

		send_idle_pct = 45;
		recv_idle_pct = 13;
		push_random_reqs(ITEMS_PHASE);
		wait_drained();

		// no idling; response side blocked for a while so the core backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rsp_hold_left = RSP_HOLD;
		push_random_reqs(ITEMS_PHASE);
		wait_drained();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
